// ===== rtl/pca_pkg.sv =====
// Shared types and constants of the pair covariance accumulator.
package pca_pkg;

  // Sizes fixed by the item fields: three site bits and two state bits.
  localparam int MAX_SITES  = 8;
  localparam int MAX_STATES = 4;
  localparam int SITE_W     = $clog2(MAX_SITES);
  localparam int STATE_W    = $clog2(MAX_STATES);
  localparam int NSITES_W   = $clog2(MAX_SITES + 1);

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SITES_IN_USE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_N_SAMPLES    = 1'b1;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [3:0]  SITES_IN_USE_RESET = 4'd5;
  localparam logic [15:0] N_SAMPLES_RESET    = 16'd1000;

  // Item operation codes.
  localparam logic OP_FEED  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic       op;
    logic [1:0] symbol;
    logic [2:0] site_first;
    logic [2:0] site_second;
    logic [1:0] state_first;
    logic [1:0] state_second;
  } in_item_t;

  typedef struct packed {
    logic signed [32:0] corr_scaled;
    logic [15:0]        samples_done;
  } out_item_t;

  // Query as it travels from the front end to the back end.
  typedef struct packed {
    logic        valid;
    logic [2:0]  site_first;
    logic [2:0]  site_second;
    logic [1:0]  state_first;
    logic [1:0]  state_second;
    logic [15:0] samples_done;
    logic [15:0] n_samples;
  } qry_cmd_t;

endpackage

// ===== rtl/pair_covariance_accumulator_unit.sv =====
// Top level of the pair covariance accumulator.
//
// This block accumulates categorical samples one site symbol at a time and
// answers queries for the connected pair correlation scaled by n_samples
// squared, that is n_samples * pair_count - single_first * single_second.
// An item with op low feeds one symbol; once sites_in_use symbols have
// arrived, the sample is complete and adds to the per-site state counts and
// to the pair counts of every site pair, diagonal included. Feeds after
// n_samples complete samples change nothing. An item with op high is a query
// and yields one result item; its correlation is zero unless the first site
// is below the second and both are in use. A front end takes items at one
// per cycle while its four-entry command queue has room; the back end owns
// the count memories. A completed sample takes the back end through a
// dispatch state, one pair update per cycle through the read port of the
// pair-count RAM for each of the L(L+1)/2 pairs of L sites in use, and a
// drain state; a query takes two reads, one multiply stage and one subtract,
// and waits while the result queue is full. After reset the block clears
// both count memories, one entry per cycle, over all pair-RAM addresses,
// 2^(2*clog2(MAX_SITES) + 2*clog2(MAX_STATES)) of them (1024 by default);
// full stays high meanwhile, and configuration writes are taken as
// usual. Configuration should only be written while the block is idle.
module pair_covariance_accumulator_unit import pca_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  in_item_t               item,
  output logic                   full,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ST    = $clog2(MAX_STATES);
  localparam int NSW   = $clog2(MAX_SITES + 1);
  localparam int CMD_W = 1 + $bits(qry_cmd_t) + NSW + MAX_SITES * ST;
  localparam int RES_W = $bits(out_item_t);

  // Front end to command queue.
  logic                         f_push;
  logic                         f_kind;
  qry_cmd_t                     f_qry;
  logic [NSW-1:0]               f_nsites;
  logic [MAX_SITES-1:0][ST-1:0] f_sample;
  logic                         cmd_full;
  logic                         cmd_empty;

  // Command queue to back end.
  logic [CMD_W-1:0]             cmd_rdata;
  logic                         b_pop;
  logic                         b_kind;
  qry_cmd_t                     b_qry;
  logic [NSW-1:0]               b_nsites;
  logic [MAX_SITES-1:0][ST-1:0] b_sample;
  logic                         clearing;

  // Back end to result queue.
  logic                         res_push;
  out_item_t                    res_item;
  logic                         res_full;
  logic [RES_W-1:0]             res_rdata;

  assign {b_kind, b_qry, b_nsites, b_sample} = cmd_rdata;
  assign result = res_rdata;

  pca_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_full   (cmd_full),
    .clearing   (clearing),
    .cmd_push   (f_push),
    .cmd_kind   (f_kind),
    .cmd_qry    (f_qry),
    .cmd_nsites (f_nsites),
    .cmd_sample (f_sample)
  );

  pca_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_kind, f_qry, f_nsites, f_sample}),
    .full  (cmd_full),
    .pop   (b_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  pca_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (!cmd_empty),
    .cmd_pop    (b_pop),
    .cmd_kind   (b_kind),
    .cmd_qry    (b_qry),
    .cmd_nsites (b_nsites),
    .cmd_sample (b_sample),
    .clearing   (clearing),
    .res_push   (res_push),
    .res_item   (res_item),
    .res_full   (res_full)
  );

  // Result queue decouples the back end from a stalled consumer.
  pca_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

endmodule

// ===== rtl/pca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pca_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
module pca_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/pca_front.sv =====
// Front end: configuration registers, sample assembly and command issue.
module pca_front import pca_pkg::*; (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  in_item_t                              item,
  output logic                                  full,
  input  logic                                  cfg_write,
  input  logic [CFG_INDEX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data,
  input  logic                                  cmd_full,
  input  logic                                  clearing,
  output logic                                  cmd_push,
  output logic                                  cmd_kind,
  output qry_cmd_t                              cmd_qry,
  output logic [NSITES_W-1:0]                   cmd_nsites,
  output logic [MAX_SITES-1:0][STATE_W-1:0]     cmd_sample
);

  localparam int SW  = SITE_W;
  localparam int ST  = STATE_W;
  localparam int NSW = NSITES_W;
  localparam int EW  = (NSW > 4) ? NSW : 4;
  localparam int SYW = ((ST > 2) ? ST : 2) + 1;
  localparam int SIW = (NSW > 3) ? NSW : 3;

  logic [3:0]                   sites_in_use;
  logic [15:0]                  n_samples;
  logic [SW-1:0]                pos;
  logic [15:0]                  sample_count;
  logic [MAX_SITES-1:0][ST-1:0] sbuf;

  logic           accept;
  logic           done;
  logic [NSW-1:0] nsites;
  logic [ST-1:0]  sym_sat;
  logic [NSW-1:0] pos_inc;
  logic           complete;
  logic           feed_ok;
  logic           q_valid;

  assign full   = cmd_full || clearing;
  assign accept = push && !full;
  assign done   = (sample_count >= n_samples);

  // Site count saturated to 1..MAX_SITES.
  always_comb begin
    if (sites_in_use == 4'd0) begin
      nsites = NSW'(1);
    end else if (EW'(sites_in_use) > EW'(MAX_SITES)) begin
      nsites = NSW'(MAX_SITES);
    end else begin
      nsites = NSW'(sites_in_use);
    end
  end

  assign sym_sat  = (SYW'(item.symbol) >= SYW'(MAX_STATES)) ? ST'(MAX_STATES - 1)
                                                           : ST'(item.symbol);
  assign pos_inc  = NSW'(pos) + NSW'(1);
  assign complete = (pos_inc >= nsites);
  assign feed_ok  = accept && (item.op == OP_FEED) && !done;

  assign q_valid = (item.site_first < item.site_second) &&
                   (SIW'(item.site_second) < SIW'(nsites)) &&
                   (SYW'(item.state_first) < SYW'(MAX_STATES)) &&
                   (SYW'(item.state_second) < SYW'(MAX_STATES));

  assign cmd_push   = (accept && (item.op == OP_QUERY)) || (feed_ok && complete);
  assign cmd_kind   = item.op;
  assign cmd_nsites = nsites;

  always_comb begin
    cmd_qry.valid        = q_valid;
    cmd_qry.site_first   = item.site_first;
    cmd_qry.site_second  = item.site_second;
    cmd_qry.state_first  = item.state_first;
    cmd_qry.state_second = item.state_second;
    cmd_qry.samples_done = sample_count;
    cmd_qry.n_samples    = n_samples;
  end

  // The finished sample includes the symbol arriving this cycle.
  always_comb begin
    for (int k = 0; k < MAX_SITES; k++) begin
      cmd_sample[k] = (SW'(k) == pos) ? sym_sat : sbuf[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sites_in_use <= SITES_IN_USE_RESET;
      n_samples    <= N_SAMPLES_RESET;
      pos          <= '0;
      sample_count <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SITES_IN_USE: sites_in_use <= cfg_data[3:0];
          CFG_N_SAMPLES:    n_samples    <= cfg_data[15:0];
        endcase
      end
      if (feed_ok) begin
        if (complete) begin
          pos          <= '0;
          sample_count <= sample_count + 16'd1;
        end else begin
          pos <= pos + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (feed_ok) begin
      sbuf[pos] <= sym_sat;
    end
  end

endmodule

// ===== rtl/pca_back.sv =====
// Back end: count memories, pair-update walk and query arithmetic.
module pca_back import pca_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_pop,
  input  logic                              cmd_kind,
  input  qry_cmd_t                          cmd_qry,
  input  logic [NSITES_W-1:0]               cmd_nsites,
  input  logic [MAX_SITES-1:0][STATE_W-1:0] cmd_sample,
  output logic                              clearing,
  output logic                              res_push,
  output out_item_t                         res_item,
  input  logic                              res_full
);

  localparam int SW  = SITE_W;
  localparam int ST  = STATE_W;
  localparam int NSW = NSITES_W;
  localparam int CW  = COUNT_WIDTH;
  localparam int PAW = 2 * SW + 2 * ST;
  localparam int SAW = SW + ST;
  localparam int PW  = 2 * CW + 17;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_Q1    = 3'd4;
  localparam logic [2:0] S_Q2    = 3'd5;
  localparam logic [2:0] S_Q3    = 3'd6;
  localparam logic [2:0] S_Q4    = 3'd7;

  logic [2:0]                   state;
  logic [PAW-1:0]               clr_addr;
  logic                         pv;
  logic                         sv;
  logic [PAW-1:0]               pa;
  logic [SAW-1:0]               sa;
  logic [SW-1:0]                i_idx;
  logic [SW-1:0]                j_idx;
  logic [NSW-1:0]               nsites_q;
  logic [MAX_SITES-1:0][ST-1:0] rest_buf;
  logic [MAX_SITES-1:0][ST-1:0] walk_buf;
  qry_cmd_t                     qry_q;
  logic [CW-1:0]                pair_v;
  logic [CW-1:0]                single_v;
  logic [CW+15:0]               scaled_q;
  logic [2*CW-1:0]              prod_q;

  logic [PAW-1:0] pair_raddr;
  logic [PAW-1:0] pair_waddr;
  logic [CW-1:0]  pair_rdata;
  logic [CW-1:0]  pair_wdata;
  logic           pair_we;
  logic [SAW-1:0] single_raddr;
  logic [SAW-1:0] single_waddr;
  logic [CW-1:0]  single_rdata;
  logic [CW-1:0]  single_wdata;
  logic           single_we;

  logic [PAW-1:0] acc_pair_addr;
  logic [SAW-1:0] acc_single_addr;
  logic           row_end;
  logic           last_row;
  logic [SW-1:0]  q_s1;
  logic [SW-1:0]  q_s2;
  logic [ST-1:0]  q_a;
  logic [ST-1:0]  q_b;
  logic [PW-1:0]  diff;

  assign acc_pair_addr   = {i_idx, j_idx, rest_buf[0], walk_buf[0]};
  assign acc_single_addr = {i_idx, rest_buf[0]};
  assign row_end  = ((NSW'(j_idx) + NSW'(1)) == nsites_q);
  assign last_row = ((NSW'(i_idx) + NSW'(1)) == nsites_q);

  assign q_s1 = SW'(qry_q.site_first);
  assign q_s2 = SW'(qry_q.site_second);
  assign q_a  = ST'(qry_q.state_first);
  assign q_b  = ST'(qry_q.state_second);

  assign clearing = (state == S_CLEAR);
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign res_push = (state == S_Q4) && !res_full;

  assign diff = PW'(scaled_q) - PW'(prod_q);
  assign res_item.corr_scaled  = qry_q.valid ? $signed(diff[32:0]) : '0;
  assign res_item.samples_done = qry_q.samples_done;

  always_comb begin
    pair_raddr   = acc_pair_addr;
    single_raddr = acc_single_addr;
    if (state == S_Q1) begin
      pair_raddr   = {q_s1, q_s2, q_a, q_b};
      single_raddr = {q_s1, q_a};
    end else if (state == S_Q2) begin
      single_raddr = {q_s2, q_b};
    end
  end

  // Writes land in the cycle after their reads; the clearing pass zeroes both stores.
  always_comb begin
    if (state == S_CLEAR) begin
      pair_we      = 1'b1;
      pair_waddr   = clr_addr;
      pair_wdata   = '0;
      single_we    = 1'b1;
      single_waddr = clr_addr[SAW-1:0];
      single_wdata = '0;
    end else begin
      pair_we      = pv;
      pair_waddr   = pa;
      pair_wdata   = pair_rdata + CW'(1);
      single_we    = sv;
      single_waddr = sa;
      single_wdata = single_rdata + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pv       <= 1'b0;
      sv       <= 1'b0;
    end else begin
      pv <= (state == S_ACC);
      sv <= (state == S_ACC) && (i_idx == j_idx);
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PAW'(1);
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            state <= (cmd_kind == OP_QUERY) ? S_Q1 : S_ACC;
          end
        end
        S_ACC: begin
          if (row_end && last_row) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_IDLE;
        S_Q1:    state <= S_Q2;
        S_Q2:    state <= S_Q3;
        S_Q3:    state <= S_Q4;
        S_Q4: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pa <= acc_pair_addr;
    sa <= acc_single_addr;
    if (state == S_IDLE && cmd_valid) begin
      nsites_q <= cmd_nsites;
      qry_q    <= cmd_qry;
      rest_buf <= cmd_sample;
      walk_buf <= cmd_sample;
      i_idx    <= '0;
      j_idx    <= '0;
    end else if (state == S_ACC) begin
      if (row_end) begin
        i_idx    <= i_idx + SW'(1);
        j_idx    <= i_idx + SW'(1);
        rest_buf <= rest_buf >> ST;
        walk_buf <= rest_buf >> ST;
      end else begin
        j_idx    <= j_idx + SW'(1);
        walk_buf <= walk_buf >> ST;
      end
    end
    if (state == S_Q2) begin
      pair_v   <= pair_rdata;
      single_v <= single_rdata;
    end
    if (state == S_Q3) begin
      scaled_q <= (CW+16)'(qry_q.n_samples) * (CW+16)'(pair_v);
      prod_q   <= (2*CW)'(single_v) * (2*CW)'(single_rdata);
    end
  end

  pca_ram #(.WIDTH(CW), .DEPTH(1 << PAW)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  pca_ram #(.WIDTH(CW), .DEPTH(1 << SAW)) u_single_ram (
    .clk   (clk),
    .we    (single_we),
    .waddr (single_waddr),
    .wdata (single_wdata),
    .raddr (single_raddr),
    .rdata (single_rdata)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the pair covariance accumulator unit.
module testbench;
  import pca_pkg::*;

  localparam int SITES = 8;
  localparam int STATES = 4;
  localparam int ITEM_W = $bits(in_item_t);
  // Longest back-end backlog: four queued commands and one in progress at
  // the cost of a full eight-site sample each, with generous slack.
  localparam int SETTLE_CYCLES = 400;
  // Cycles without any accepted item before the run is declared hung. The
  // memory clearing pass after reset accepts no item and must fit within it.
  localparam int QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  in_item_t item = '0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  out_item_t result;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_SITES_IN_USE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pair_covariance_accumulator_unit u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item),
    .full(full),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Items waiting to be pushed, and the correlation answers that the
  // accepted queries must produce, oldest first.
  in_item_t pending_items[$];
  out_item_t awaited_answers[$];
  out_item_t want;
  int error_count = 0;
  int quiet_cycles = 0;
  int send_wait = 0;
  int pop_wait = 0;

  // Our own copy of the accumulator state and its two registers.
  logic [3:0] cfg_sites = SITES_IN_USE_RESET;
  logic [15:0] cfg_nsamp = N_SAMPLES_RESET;
  logic [1:0] sym_buf [SITES];
  int fill_pos = 0;
  logic [15:0] done_count = '0;
  logic [15:0] single_cnt [SITES][STATES];
  logic [15:0] pair_cnt [SITES][SITES][STATES][STATES];

  // Idle behavior per side (0 sender, 1 receiver): each stretch of items either
  // comes back to back or has random waits of 0 to 9, picked at random.
  int calm_left [2] = '{0, 0};
  bit calm_quiet [2] = '{1'b0, 1'b0};

  initial begin
    for (int i = 0; i < SITES; i++) begin
      sym_buf[i] = '0;
      for (int a = 0; a < STATES; a++) begin
        single_cnt[i][a] = '0;
        for (int j = 0; j < SITES; j++)
          for (int b = 0; b < STATES; b++)
            pair_cnt[i][j][a][b] = '0;
      end
    end
  end

  function automatic int draw_wait(input int side);
    if (calm_left[side] == 0) begin
      calm_left[side] = $urandom_range(10, 60);
      calm_quiet[side] = ($urandom_range(0, 2) == 0);
    end
    calm_left[side]--;
    return calm_quiet[side] ? 0 : $urandom_range(0, 9);
  endfunction

  // The site count that the block really uses: the register saturated to
  // the range one to eight.
  function automatic int live_sites();
    if (cfg_sites == 0) return 1;
    if (cfg_sites > SITES) return SITES;
    return int'(cfg_sites);
  endfunction

  // Advance our copy of the state by one accepted item. A feed may close a
  // sample, which then adds to the single counts and, once per pair with the
  // diagonal included, to the pair counts. A query produces one answer.
  function automatic void track_item(input in_item_t it);
    int nsites;
    logic [63:0] wide;
    out_item_t ans;
    nsites = live_sites();
    if (it.op == OP_FEED) begin
      // Feeds are dropped once enough samples are in, n_samples zero included.
      if (done_count < cfg_nsamp) begin
        sym_buf[fill_pos] = it.symbol;
        if (fill_pos + 1 >= nsites) begin
          for (int i = 0; i < nsites; i++) begin
            single_cnt[i][sym_buf[i]]++;
            for (int j = i; j < nsites; j++)
              pair_cnt[i][j][sym_buf[i]][sym_buf[j]]++;
          end
          fill_pos = 0;
          done_count++;
        end else begin
          fill_pos++;
        end
      end
    end else begin
      wide = '0;
      // The answer is zero unless the pair is ordered and both sites are used.
      if (it.site_first < it.site_second && int'(it.site_second) < nsites) begin
        wide = 64'(cfg_nsamp)
             * 64'(pair_cnt[it.site_first][it.site_second][it.state_first][it.state_second])
             - 64'(single_cnt[it.site_first][it.state_first])
             * 64'(single_cnt[it.site_second][it.state_second]);
      end
      ans.corr_scaled = wide[32:0];
      ans.samples_done = done_count;
      awaited_answers.push_back(ans);
    end
  endfunction

  // Fields that the operation does not use carry random bits.
  function automatic in_item_t make_feed(input logic [1:0] sym);
    in_item_t it;
    it = ITEM_W'($urandom);
    it.op = OP_FEED;
    it.symbol = sym;
    return it;
  endfunction

  function automatic in_item_t make_query(input logic [2:0] s1, input logic [2:0] s2,
                                          input logic [1:0] a, input logic [1:0] b);
    in_item_t it;
    it = ITEM_W'($urandom);
    it.op = OP_QUERY;
    it.site_first = s1;
    it.site_second = s2;
    it.state_first = a;
    it.state_second = b;
    return it;
  endfunction

  // Random traffic: mostly symbol feeds that build samples, about a quarter
  // queries (three in four of them on a valid pair when one exists), and a
  // few items of pure noise.
  task automatic queue_random(input int count);
    int roll;
    int nsites;
    int s1;
    int s2;
    in_item_t it;
    nsites = live_sites();
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        it = ITEM_W'($urandom);
      end else if (roll < 30) begin
        if (nsites >= 2 && $urandom_range(0, 3) != 0) begin
          s2 = $urandom_range(1, nsites - 1);
          s1 = $urandom_range(0, s2 - 1);
        end else begin
          s1 = $urandom_range(0, SITES - 1);
          s2 = $urandom_range(0, SITES - 1);
        end
        it = make_query(3'(s1), 3'(s2), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end else begin
        it = make_feed(2'($urandom_range(0, 3)));
      end
      pending_items.push_back(it);
    end
  endtask

  // Wait until every queued item is taken and every answer is back, then
  // give the back end time to finish sample updates that produce no answer.
  // The check runs at the falling edge, where the sender's updates have
  // settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || push || awaited_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers are written only while the block is idle, and our copy
  // follows at once.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_SITES_IN_USE) begin
      cfg_sites = value[3:0];
    end else begin
      cfg_nsamp = value;
    end
  endtask

  // One phase: new register values, random traffic, then a full drain. The
  // drain also holds back the next phase until every answer has come back.
  task automatic run_phase(input int sites, input int nsamp, input int count);
    write_reg(CFG_SITES_IN_USE, 16'(sites));
    write_reg(CFG_N_SAMPLES, 16'(nsamp));
    queue_random(count);
    wait_drained();
  endtask

  // Sender: takes items from the pending queue and holds each one until the
  // block accepts it, with a random wait drawn after every accepted item.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_wait = 0;
    end else begin
      if (push && !full) begin
        track_item(item);
        send_wait = draw_wait(0);
      end
      if (!(push && full)) begin
        if (send_wait > 0 || pending_items.size() == 0) begin
          if (send_wait > 0) send_wait--;
          push <= 1'b0;
        end else begin
          item <= pending_items.pop_front();
          push <= 1'b1;
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest awaited answer
  // and stalls at random between results.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (awaited_answers.size() == 0) begin
          $error("unexpected result: corr_scaled %0d samples_done %0d",
                 result.corr_scaled, result.samples_done);
          error_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (result.corr_scaled !== want.corr_scaled) begin
            $error("corr_scaled: expected %0d, got %0d", want.corr_scaled, result.corr_scaled);
            error_count++;
          end
          if (result.samples_done !== want.samples_done) begin
            $error("samples_done: expected %0d, got %0d",
                   want.samples_done, result.samples_done);
            error_count++;
          end
        end
        pop_wait = draw_wait(1);
      end else if (pop_wait > 0) begin
        pop_wait--;
      end
      pop <= (pop_wait == 0);
    end
  end

  // Watchdog: a long stretch in which no item moves on either side means
  // the block is hung.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset register values (five sites, 1000 samples).
    // A query before any sample must read all-zero counts.
    pending_items.push_back(make_query(3'd0, 3'd1, 2'd0, 2'd0));
    // Two complete samples, all symbol values among them.
    pending_items.push_back(make_feed(2'd0));
    pending_items.push_back(make_feed(2'd1));
    pending_items.push_back(make_feed(2'd2));
    pending_items.push_back(make_feed(2'd3));
    pending_items.push_back(make_feed(2'd3));
    pending_items.push_back(make_feed(2'd1));
    pending_items.push_back(make_feed(2'd2));
    pending_items.push_back(make_feed(2'd3));
    pending_items.push_back(make_feed(2'd0));
    pending_items.push_back(make_feed(2'd3));
    // Valid pairs, including the outermost sites and states in use.
    pending_items.push_back(make_query(3'd0, 3'd1, 2'd0, 2'd1));
    pending_items.push_back(make_query(3'd0, 3'd4, 2'd0, 2'd3));
    pending_items.push_back(make_query(3'd3, 3'd4, 2'd3, 2'd3));
    pending_items.push_back(make_query(3'd2, 3'd3, 2'd1, 2'd2));
    // Invalid queries: diagonal, reversed pair, site beyond the count in use,
    // both sites at the top of the range, a pair above the count in use.
    pending_items.push_back(make_query(3'd1, 3'd1, 2'd1, 2'd1));
    pending_items.push_back(make_query(3'd3, 3'd2, 2'd3, 2'd2));
    pending_items.push_back(make_query(3'd0, 3'd5, 2'd0, 2'd0));
    pending_items.push_back(make_query(3'd7, 3'd7, 2'd3, 2'd3));
    pending_items.push_back(make_query(3'd6, 3'd7, 2'd0, 2'd3));
    queue_random(100);
    wait_drained();

    // Widest sample and largest scale.
    run_phase(8, 65535, 250);
    run_phase(2, 65535, 100);
    // A site count above eight saturates to eight.
    run_phase(15, 65535, 100);
    // Leave a sample half built at position five so that the next phase
    // lowers the site count in the middle of a sample.
    repeat ((13 - fill_pos) % 8) pending_items.push_back(make_feed(2'($urandom_range(0, 3))));
    wait_drained();
    // A site count of zero counts as one: every feed closes a sample and no
    // query has a valid pair.
    run_phase(0, 65535, 80);
    // A sample limit just above the count so far: later feeds are dropped.
    run_phase(3, int'(done_count) + 5, 120);
    // No samples at all, then the smallest nonzero limit.
    run_phase(6, 0, 60);
    run_phase(1, 1, 40);
    run_phase(7, 65535, 200);
    run_phase(4, 40000, 100);

    if (error_count == 0 && awaited_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== pair_covariance_accumulator_unit.f =====
rtl/pca_pkg.sv
rtl/pca_ram.sv
rtl/pca_fifo.sv
rtl/pca_front.sv
rtl/pca_back.sv
rtl/pair_covariance_accumulator_unit.sv
sim/testbench.sv
